[src/rsd_pkg.sv]
// ----------------------------------------------------------------------------
// rsd_pkg - shared types and constants for the RLE sprite decoder
// Field widths, configuration register indexes and the status word
// passed from the position unit to the sequencer.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int BYTE_BITS    = 8;
  localparam int COORD_BITS   = 16;
  localparam int CFG_BITS     = 15;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRANSPARENT = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAW_MODE    = 2'd3;

  typedef struct packed {
    logic col_ge_w;
    logic row_ge_h;
  } rsd_pos_stat_t;

endpackage

[src/rsd_if.sv]
// ----------------------------------------------------------------------------
// rsd_if - stream channels of the RLE sprite decoder
// Byte input channel and block result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsd_in_if;
  logic                          valid;
  logic                          ready;
  logic [rsd_pkg::BYTE_BITS-1:0] data_byte;
  logic                          frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface rsd_out_if;
  logic                           valid;
  logic                           ready;
  logic                           write_block;
  logic [rsd_pkg::COORD_BITS-1:0] block_x;
  logic [rsd_pkg::COORD_BITS-1:0] block_y;
  logic [rsd_pkg::BYTE_BITS-1:0]  pixel_color;
  logic                           frame_done;

  modport source (output valid, write_block, block_x, block_y, pixel_color, frame_done,
                  input ready);
  modport sink   (input valid, write_block, block_x, block_y, pixel_color, frame_done,
                  output ready);
endinterface

[src/rsd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rsd_cfg_regs - configuration registers
// Holds the frame size, transparent colour and mode; presents the frame
// size trimmed to the position width with zero read as one.
// ----------------------------------------------------------------------------
module rsd_cfg_regs #(
  parameter int DIM_BITS = 15
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rsd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [rsd_pkg::CFG_BITS-1:0]     cfg_data,
  output logic [DIM_BITS-1:0]              width_dim,
  output logic [DIM_BITS-1:0]              height_dim,
  output logic [rsd_pkg::BYTE_BITS-1:0]    transparent_color,
  output logic                             raw_mode
);
  import rsd_pkg::*;

  logic [CFG_BITS-1:0] src_width;
  logic [CFG_BITS-1:0] src_height;
  logic [DIM_BITS-1:0] width_trim;
  logic [DIM_BITS-1:0] height_trim;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width         <= CFG_BITS'(1);
      src_height        <= CFG_BITS'(1);
      transparent_color <= '0;
      raw_mode          <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:   src_width         <= cfg_data;
        REG_SRC_HEIGHT:  src_height        <= cfg_data;
        REG_TRANSPARENT: transparent_color <= cfg_data[BYTE_BITS-1:0];
        REG_RAW_MODE:    raw_mode          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign width_trim  = src_width[DIM_BITS-1:0];
  assign height_trim = src_height[DIM_BITS-1:0];

  // a zero size counts as one
  assign width_dim  = (width_trim == '0)  ? DIM_BITS'(1) : width_trim;
  assign height_dim = (height_trim == '0) ? DIM_BITS'(1) : height_trim;

endmodule

[src/rsd_pos_unit.sv]
// ----------------------------------------------------------------------------
// rsd_pos_unit - shared position normalising unit
// One width subtraction and the row and column bound compares, used once
// per sequencer step to fold the working column into the row count.
// ----------------------------------------------------------------------------
module rsd_pos_unit #(
  parameter int DIM_BITS = 15
) (
  input  logic [DIM_BITS:0]           col,
  input  logic [DIM_BITS-1:0]         row,
  input  logic [DIM_BITS-1:0]         width_dim,
  input  logic [DIM_BITS-1:0]         height_dim,
  output logic [DIM_BITS:0]           col_sub,
  output logic [DIM_BITS-1:0]         row_inc,
  output rsd_pkg::rsd_pos_stat_t      stat
);
  import rsd_pkg::*;

  logic [DIM_BITS:0] width_ext;

  assign width_ext     = {1'b0, width_dim};
  assign col_sub       = col - width_ext;
  assign row_inc       = row + DIM_BITS'(1);
  assign stat.col_ge_w = (col >= width_ext);
  assign stat.row_ge_h = (row >= height_dim);

endmodule

[src/rle_sprite_decode_pixel_double.sv]
// ----------------------------------------------------------------------------
// rle_sprite_decode_pixel_double - RLE sprite decoder with 2x upscale
// Decodes transparent-run compressed or raw sprite bytes into 2x2 block
// writes on a doubled frame, flagging the end of the frame.
// ----------------------------------------------------------------------------
// One byte is taken at a time. A run marker byte passes S_NORM_A only; a
// pixel or run count byte passes S_NORM_A and S_NORM_B. A state repeats for
// every row end that the advance crosses, since a single width subtractor
// folds the column into the row one row per cycle (a run of up to 256
// pixels on a narrow frame, or a position left beyond a shrunk width, takes
// that many folds). A byte after the frame end is dropped. The result sits in
// an output register, so the next byte is taken while it waits; a new result
// waits only if the previous one has not yet been taken. No clearing pass.
module rle_sprite_decode_pixel_double #(
  parameter int DIM_BITS = 15
) (
  input  logic                             clk,
  input  logic                             rst,
  rsd_in_if.sink                           pixel_in,
  rsd_out_if.source                        block_out,
  input  logic                             cfg_we,
  input  logic [rsd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [rsd_pkg::CFG_BITS-1:0]     cfg_data
);
  import rsd_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_NORM_A = 2'd1;
  localparam logic [1:0] S_NORM_B = 2'd2;

  logic [1:0]           state;
  logic [DIM_BITS-1:0]  column_pos;
  logic [DIM_BITS-1:0]  row_pos;
  logic                 expect_count;
  logic                 finished;
  logic [DIM_BITS:0]    wcol;
  logic [DIM_BITS-1:0]  wrow;
  logic [BYTE_BITS-1:0] byte_q;
  logic                 do_write;

  logic                  res_valid;
  logic                  res_write;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;
  logic [BYTE_BITS-1:0]  res_color;
  logic                  res_done;

  logic [DIM_BITS-1:0]  width_dim;
  logic [DIM_BITS-1:0]  height_dim;
  logic [BYTE_BITS-1:0] transparent_color;
  logic                 raw_mode;

  logic [DIM_BITS:0]    col_sub;
  logic [DIM_BITS-1:0]  row_inc;
  rsd_pos_stat_t        stat;
  logic                 emit_ok;
  logic                 res_load;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;

  rsd_cfg_regs #(.DIM_BITS(DIM_BITS)) u_cfg (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .width_dim         (width_dim),
    .height_dim        (height_dim),
    .transparent_color (transparent_color),
    .raw_mode          (raw_mode)
  );

  rsd_pos_unit #(.DIM_BITS(DIM_BITS)) u_pos (
    .col        (wcol),
    .row        (wrow),
    .width_dim  (width_dim),
    .height_dim (height_dim),
    .col_sub    (col_sub),
    .row_inc    (row_inc),
    .stat       (stat)
  );

  assign pixel_in.ready = (state == S_IDLE);
  assign emit_ok        = !res_valid || block_out.ready;
  // a new word is loaded into the output register this cycle
  assign res_load       = emit_ok &&
                          (((state == S_NORM_A) && stat.row_ge_h) ||
                           ((state == S_NORM_B) &&
                            (stat.row_ge_h || (!stat.col_ge_w && do_write))));
  // block coordinates come from the stored position, not the folded one
  assign cur_x          = COORD_BITS'({column_pos, 1'b0});
  assign cur_y          = COORD_BITS'({row_pos, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      column_pos   <= '0;
      row_pos      <= '0;
      expect_count <= 1'b0;
      finished     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (block_out.ready && !res_load) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pixel_in.valid) begin
            byte_q <= pixel_in.data_byte;
            if (pixel_in.frame_start) begin
              column_pos   <= '0;
              row_pos      <= '0;
              expect_count <= 1'b0;
              finished     <= 1'b0;
              wcol         <= '0;
              wrow         <= '0;
              state        <= S_NORM_A;
            end else if (!finished) begin
              wcol  <= {1'b0, column_pos};
              wrow  <= row_pos;
              state <= S_NORM_A;
            end
          end
        end
        S_NORM_A: begin
          if (stat.row_ge_h) begin
            // position already past the end: consume, flag done
            if (emit_ok) begin
              res_valid    <= 1'b1;
              res_write    <= 1'b0;
              res_x        <= '0;
              res_y        <= '0;
              res_color    <= '0;
              res_done     <= 1'b1;
              expect_count <= 1'b0;
              finished     <= 1'b1;
              state        <= S_IDLE;
            end
          end else if (stat.col_ge_w) begin
            wcol <= col_sub;
            wrow <= row_inc;
          end else if (raw_mode) begin
            expect_count <= 1'b0;
            do_write     <= 1'b1;
            wcol         <= wcol + (DIM_BITS+1)'(1);
            state        <= S_NORM_B;
          end else if (expect_count) begin
            expect_count <= 1'b0;
            do_write     <= 1'b0;
            wcol         <= wcol + (DIM_BITS+1)'(byte_q) + (DIM_BITS+1)'(1);
            state        <= S_NORM_B;
          end else if (byte_q == transparent_color) begin
            expect_count <= 1'b1;
            state        <= S_IDLE;
          end else begin
            do_write <= 1'b1;
            wcol     <= wcol + (DIM_BITS+1)'(1);
            state    <= S_NORM_B;
          end
        end
        S_NORM_B: begin
          if (stat.row_ge_h) begin
            // clamp at the frame end
            if (emit_ok) begin
              res_valid  <= 1'b1;
              res_write  <= do_write;
              res_x      <= do_write ? cur_x : '0;
              res_y      <= do_write ? cur_y : '0;
              res_color  <= do_write ? byte_q : '0;
              res_done   <= 1'b1;
              finished   <= 1'b1;
              column_pos <= '0;
              row_pos    <= height_dim;
              state      <= S_IDLE;
            end
          end else if (stat.col_ge_w) begin
            wcol <= col_sub;
            wrow <= row_inc;
          end else if (!do_write) begin
            column_pos <= wcol[DIM_BITS-1:0];
            row_pos    <= wrow;
            state      <= S_IDLE;
          end else if (emit_ok) begin
            res_valid  <= 1'b1;
            res_write  <= 1'b1;
            res_x      <= cur_x;
            res_y      <= cur_y;
            res_color  <= byte_q;
            res_done   <= 1'b0;
            column_pos <= wcol[DIM_BITS-1:0];
            row_pos    <= wrow;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign block_out.valid       = res_valid;
  assign block_out.write_block = res_write;
  assign block_out.block_x     = res_x;
  assign block_out.block_y     = res_y;
  assign block_out.pixel_color = res_color;
  assign block_out.frame_done  = res_done;

  a_idle_word_is_done: assert property (@(posedge clk) disable iff (rst)
    (block_out.valid && !block_out.write_block) |-> block_out.frame_done)
    else $error("result word carries neither a write nor done");

  a_finished_no_count: assert property (@(posedge clk) disable iff (rst)
    finished |-> !expect_count)
    else $error("count pending after frame end");

  a_drop_after_end: assert property (@(posedge clk) disable iff (rst)
    (pixel_in.valid && pixel_in.ready && finished && !pixel_in.frame_start)
      |=> (state == S_IDLE))
    else $error("byte after frame end was not dropped");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (pixel_in.valid && pixel_in.ready && pixel_in.frame_start)
      |=> (column_pos == '0 && row_pos == '0 && !finished && !expect_count))
    else $error("frame start did not clear the position");

endmodule
